// File: sv/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types and constants for the SRv6 routing header flag advance block.
// ----------------------------------------------------------------------------
package sfa_pkg;

	// Internal arithmetic width for lengths and offsets (covers 4096 + header slack)
	localparam int CALC_W  = 14;
	localparam int PATCH_W = 12;
	localparam int IDX_W   = 4;

	// Fixed packet layout
	localparam int IP6_HDR_BYTES   = 40;
	localparam int SRH_FIXED_BYTES = 8;
	localparam int SEG_BYTES       = 16;
	localparam int NH_ROUTING      = 43;
	localparam int SR_TYPE_4       = 4;

	localparam int OFF_NEXT_HDR = 6;
	localparam int OFF_DA       = 24;
	localparam int OFF_DA10     = 34;
	localparam int OFF_DA11     = 35;
	localparam int OFF_HDRLEN   = 41;
	localparam int OFF_TYPE     = 42;
	localparam int OFF_SL       = 43;
	localparam int OFF_FIRST    = 44;

	// Verdict codes
	localparam logic [1:0] VERDICT_PASS    = 2'd0;
	localparam logic [1:0] VERDICT_DROP    = 2'd1;
	localparam logic [1:0] VERDICT_REROUTE = 2'd2;

	// Front-end classification of a finished packet
	typedef enum logic [1:0] {
		JOB_PASS,
		JOB_DROP,
		JOB_CHECK
	} job_kind_t;

	typedef struct packed {
		job_kind_t           kind;
		logic                bank;
		logic [CALC_W-1:0]   len;
		logic [CALC_W-1:0]   resv;
		logic [7:0]          first;
		logic [7:0]          sl;
		logic                flag;
	} job_t;

	// One result item
	typedef struct packed {
		logic               patch_valid;
		logic [PATCH_W-1:0] patch_offset;
		logic [7:0]         patch_value;
		logic [1:0]         verdict;
		logic               end_of_results;
	} res_t;

	// Buffer bank release from back end to front end
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

endpackage

// File: sv/srv6_srh_flag_advance.sv
// ----------------------------------------------------------------------------
// srv6_srh_flag_advance
// SRv6 End processing with a flag byte in the reserved bytes after the
// segment list: buffers a packet, then emits byte patches and a verdict.
// ----------------------------------------------------------------------------
//
//   channel   handshake           payload
//   -------   -----------------   -------------------------------------------
//   input     push / full         data_byte, last_byte
//   result    pop / empty         patch_valid, patch_offset, patch_value,
//                                 verdict, end_of_results
//   config    cfg_we              cfg_wdata (mode)
//
// Bytes are taken one per cycle, while full is low, into one of two packet
// banks; a packet end queues a job. A reroute (embedder or selector) is paced
// by the single buffer read port: each of the 16 segment bytes is read and
// then transferred as a patch. full is high only while both banks hold
// unfinished packets; a withheld pop stalls the back end once the two-entry
// result queue fills. Reset clears counters and bank state.
//
module srv6_srh_flag_advance #(
	parameter int MAX_SRH_BYTES  = 2048,
	parameter int BUF_BYTES      = 4096,
	parameter int RESERVED_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output logic        empty,
	input  logic        pop,
	output logic        patch_valid,
	output logic [11:0] patch_offset,
	output logic [7:0]  patch_value,
	output logic [1:0]  verdict,
	output logic        end_of_results
);

	localparam int AW    = $clog2(BUF_BYTES);
	localparam int JOB_W = $bits(sfa_pkg::job_t);
	localparam int RES_W = $bits(sfa_pkg::res_t);

	logic               mode_q;
	logic               mem_we;
	logic [AW:0]        mem_waddr;
	logic [7:0]         mem_wdata;
	logic [AW:0]        mem_raddr;
	logic [7:0]         mem_rdata;
	logic               jq_push;
	logic               jq_full;
	logic               jq_pop;
	logic               jq_empty;
	sfa_pkg::job_t      job_w;
	logic [JOB_W-1:0]   jq_rdata;
	logic               rq_push;
	logic               rq_full;
	sfa_pkg::res_t      res_w;
	logic [RES_W-1:0]   rq_rdata;
	sfa_pkg::res_t      res_out;
	sfa_pkg::rel_t      rel;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	sfa_front #(
		.MAX_SRH_BYTES  (MAX_SRH_BYTES),
		.BUF_BYTES      (BUF_BYTES),
		.RESERVED_BYTES (RESERVED_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.rel       (rel),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.job_push  (jq_push),
		.job       (job_w)
	);

	// Two banks of packet buffer
	sfa_ram #(
		.WIDTH (8),
		.DEPTH (2 * (2 ** AW))
	) u_buf (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sfa_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (2)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (jq_push),
		.wdata  (job_w),
		.full   (jq_full),
		.pop    (jq_pop),
		.rdata  (jq_rdata),
		.empty  (jq_empty)
	);

	sfa_back #(
		.BUF_BYTES      (BUF_BYTES),
		.RESERVED_BYTES (RESERVED_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.job_empty (jq_empty),
		.job_in    (sfa_pkg::job_t'(jq_rdata)),
		.job_pop   (jq_pop),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_full  (rq_full),
		.res_push  (rq_push),
		.res       (res_w),
		.rel       (rel)
	);

	sfa_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (res_w),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rdata),
		.empty  (empty)
	);

	// Unpack the oldest result
	assign res_out        = sfa_pkg::res_t'(rq_rdata);
	assign patch_valid    = res_out.patch_valid;
	assign patch_offset   = res_out.patch_offset;
	assign patch_value    = res_out.patch_value;
	assign verdict        = res_out.verdict;
	assign end_of_results = res_out.end_of_results;

	// Two banks bound the outstanding jobs, so the job queue never overflows
	a_jobq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		jq_push |-> !jq_full)
		else $error("job queue pushed while full");

	// Back end takes a job only when one is queued
	a_jobq_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		jq_pop |-> !jq_empty)
		else $error("job queue popped while empty");

	// A bank is released exactly with the closing result of its packet
	a_release_with_close: assert property (@(posedge clk) disable iff (!arst_n)
		rel.valid |-> (rq_push && !rq_full && res_w.end_of_results))
		else $error("bank released without closing result");

	// After a packet end the written bank is locked against new bytes
	a_bank_locked: assert property (@(posedge clk) disable iff (!arst_n)
		(jq_push && !rel.valid) |=> (mem_we |-> mem_waddr[AW] != $past(mem_waddr[AW])))
		else $error("write into a bank still awaiting the back end");

endmodule

// File: sv/sfa_ram.sv
// ----------------------------------------------------------------------------
// sfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/sfa_fifo.sv
// ----------------------------------------------------------------------------
// sfa_fifo
// Small register FIFO with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module sfa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [NW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == NW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/sfa_front.sv
// ----------------------------------------------------------------------------
// sfa_front
// Byte intake: buffers packet bytes into one of two banks, captures fixed
// header fields and classifies the packet on its last byte.
// ----------------------------------------------------------------------------
module sfa_front #(
	parameter int MAX_SRH_BYTES  = 2048,
	parameter int BUF_BYTES      = 4096,
	parameter int RESERVED_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    data_byte,
	input  logic                          last_byte,
	input  sfa_pkg::rel_t                 rel,
	output logic                          mem_we,
	output logic [$clog2(BUF_BYTES):0]    mem_waddr,
	output logic [7:0]                    mem_wdata,
	output logic                          job_push,
	output sfa_pkg::job_t                 job
);

	localparam int AW = $clog2(BUF_BYTES);
	localparam int CW = $clog2(BUF_BYTES + 1);
	localparam int W  = sfa_pkg::CALC_W;

	logic [CW-1:0] count_q;
	logic          wbank_q;
	logic [1:0]    busy_q;
	logic [7:0]    nh_q;
	logic [7:0]    da10_q;
	logic [7:0]    da11_q;
	logic [7:0]    hdrlen_q;
	logic [7:0]    rtype_q;
	logic [7:0]    sl_q;
	logic [7:0]    first_q;

	logic          acc;
	logic          in_buf;
	logic [W-1:0]  len_c;
	logic [W-1:0]  srh_len;
	logic [W-1:0]  tlv_rel;
	logic [W-1:0]  resv;
	logic [1:0]    busy_n;

	assign full      = busy_q[wbank_q];
	assign acc       = push && !full;
	assign in_buf    = (count_q < CW'(BUF_BYTES));
	assign mem_we    = acc && in_buf;
	assign mem_waddr = {wbank_q, count_q[AW-1:0]};
	assign mem_wdata = data_byte;
	assign job_push  = acc && last_byte;

	// Length after this byte, holding at the buffer size
	assign len_c   = in_buf ? W'(count_q) + W'(1) : W'(count_q);
	assign srh_len = (W'(hdrlen_q) + W'(1)) << 3;
	assign tlv_rel = W'(sfa_pkg::SRH_FIXED_BYTES) + ((W'(first_q) + W'(1)) << 4);
	assign resv    = W'(sfa_pkg::IP6_HDR_BYTES) + tlv_rel;

	// Classify the packet in check order
	always_comb begin
		job       = '0;
		job.bank  = wbank_q;
		job.len   = len_c;
		job.resv  = resv;
		job.first = first_q;
		job.sl    = sl_q;
		job.flag  = (da10_q != 8'd0) || (da11_q != 8'd0);
		if (len_c < W'(sfa_pkg::IP6_HDR_BYTES)) begin
			job.kind = sfa_pkg::JOB_DROP;
		end else if (nh_q != 8'(sfa_pkg::NH_ROUTING)) begin
			job.kind = sfa_pkg::JOB_PASS;
		end else if (len_c < W'(sfa_pkg::IP6_HDR_BYTES + sfa_pkg::SRH_FIXED_BYTES)) begin
			job.kind = sfa_pkg::JOB_DROP;
		end else if (rtype_q != 8'(sfa_pkg::SR_TYPE_4)) begin
			job.kind = sfa_pkg::JOB_DROP;
		end else if (srh_len > W'(MAX_SRH_BYTES)
				|| W'(sfa_pkg::IP6_HDR_BYTES) + srh_len > len_c) begin
			job.kind = sfa_pkg::JOB_DROP;
		end else if (tlv_rel > srh_len
				|| srh_len < tlv_rel + W'(RESERVED_BYTES)) begin
			job.kind = sfa_pkg::JOB_DROP;
		end else if (resv + W'(RESERVED_BYTES) > len_c) begin
			job.kind = sfa_pkg::JOB_DROP;
		end else begin
			job.kind = sfa_pkg::JOB_CHECK;
		end
	end

	// Bank ownership: set on packet end, clear on release from the back end
	always_comb begin
		busy_n = busy_q;
		if (rel.valid) begin
			busy_n[rel.bank] = 1'b0;
		end
		if (job_push) begin
			busy_n[wbank_q] = 1'b1;
		end
	end

	// Count bytes and track banks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wbank_q <= 1'b0;
			busy_q  <= '0;
		end else begin
			busy_q <= busy_n;
			if (acc) begin
				if (last_byte) begin
					count_q <= '0;
					wbank_q <= ~wbank_q;
				end else if (in_buf) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// Capture fixed header fields as they stream by
	always_ff @(posedge clk) begin
		if (acc) begin
			if (count_q == CW'(sfa_pkg::OFF_NEXT_HDR)) nh_q     <= data_byte;
			if (count_q == CW'(sfa_pkg::OFF_DA10))     da10_q   <= data_byte;
			if (count_q == CW'(sfa_pkg::OFF_DA11))     da11_q   <= data_byte;
			if (count_q == CW'(sfa_pkg::OFF_HDRLEN))   hdrlen_q <= data_byte;
			if (count_q == CW'(sfa_pkg::OFF_TYPE))     rtype_q  <= data_byte;
			if (count_q == CW'(sfa_pkg::OFF_SL))       sl_q     <= data_byte;
			if (count_q == CW'(sfa_pkg::OFF_FIRST))    first_q  <= data_byte;
		end
	end

endmodule

// File: sv/sfa_back.sv
// ----------------------------------------------------------------------------
// sfa_back
// Job execution: finishes the segment checks, reads the buffered packet and
// emits any byte patches followed by the closing verdict.
// ----------------------------------------------------------------------------
module sfa_back #(
	parameter int BUF_BYTES      = 4096,
	parameter int RESERVED_BYTES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       mode,
	input  logic                       job_empty,
	input  sfa_pkg::job_t              job_in,
	output logic                       job_pop,
	output logic [$clog2(BUF_BYTES):0] mem_raddr,
	input  logic [7:0]                 mem_rdata,
	input  logic                       res_full,
	output logic                       res_push,
	output sfa_pkg::res_t              res,
	output sfa_pkg::rel_t              rel
);

	localparam int AW = $clog2(BUF_BYTES);
	localparam int W  = sfa_pkg::CALC_W;
	localparam int IW = sfa_pkg::IDX_W;
	localparam int PW = sfa_pkg::PATCH_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RESV,
		ST_EVAL,
		ST_FLAG,
		ST_SLP,
		ST_SEG_RD,
		ST_SEG_WR,
		ST_CLOSE
	} state_t;

	state_t        state_q;
	sfa_pkg::job_t job_q;
	logic [7:0]    next_q;
	logic [W-1:0]  seg_q;
	logic [IW-1:0] idx_q;
	logic [1:0]    verdict_q;

	logic [1:0]    step;
	logic [7:0]    next_c;
	logic [W-1:0]  seg_c;
	logic          eval_drop;
	logic [W-1:0]  rd_pos;

	// Step and segments-left checks
	assign step      = (mode && mem_rdata != 8'd0) ? 2'd2 : 2'd1;
	assign next_c    = job_q.sl - 8'(step);
	assign seg_c     = W'(sfa_pkg::IP6_HDR_BYTES + sfa_pkg::SRH_FIXED_BYTES)
	                 + (W'(next_c) << 4);
	assign eval_drop = (job_q.sl < 8'(step)) || (next_c > job_q.first)
	                 || (seg_c + W'(sfa_pkg::SEG_BYTES) > job_q.len);

	// Read address: reserved byte while checking, segment byte while copying
	assign rd_pos    = (state_q == ST_SEG_RD || state_q == ST_SEG_WR)
	                 ? seg_q + W'(idx_q) : job_q.resv;
	assign mem_raddr = {job_q.bank, rd_pos[AW-1:0]};

	// Result and handshake outputs
	always_comb begin
		job_pop   = 1'b0;
		res_push  = 1'b0;
		res       = '0;
		rel.valid = 1'b0;
		rel.bank  = job_q.bank;
		unique case (state_q)
			ST_IDLE: begin
				job_pop = !job_empty;
			end
			ST_FLAG: begin
				res_push          = !res_full;
				res.patch_valid   = 1'b1;
				res.patch_offset  = PW'(job_q.resv + W'(idx_q));
				res.patch_value   = mode ? 8'd0 : 8'(job_q.flag);
			end
			ST_SLP: begin
				res_push          = !res_full;
				res.patch_valid   = 1'b1;
				res.patch_offset  = PW'(sfa_pkg::OFF_SL);
				res.patch_value   = next_q;
			end
			ST_SEG_WR: begin
				res_push          = !res_full;
				res.patch_valid   = 1'b1;
				res.patch_offset  = PW'(sfa_pkg::OFF_DA) + PW'(idx_q);
				res.patch_value   = mem_rdata;
			end
			ST_CLOSE: begin
				res_push           = !res_full;
				res.verdict        = verdict_q;
				res.end_of_results = 1'b1;
				rel.valid          = !res_full;
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			job_q     <= '0;
			next_q    <= '0;
			seg_q     <= '0;
			idx_q     <= '0;
			verdict_q <= sfa_pkg::VERDICT_PASS;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						job_q <= job_in;
						idx_q <= '0;
						unique case (job_in.kind)
							sfa_pkg::JOB_PASS: begin
								verdict_q <= sfa_pkg::VERDICT_PASS;
								state_q   <= ST_CLOSE;
							end
							sfa_pkg::JOB_CHECK: begin
								verdict_q <= sfa_pkg::VERDICT_REROUTE;
								state_q   <= ST_RESV;
							end
							default: begin
								verdict_q <= sfa_pkg::VERDICT_DROP;
								state_q   <= ST_CLOSE;
							end
						endcase
					end
				end
				ST_RESV: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					next_q <= next_c;
					seg_q  <= seg_c;
					if (eval_drop) begin
						verdict_q <= sfa_pkg::VERDICT_DROP;
						state_q   <= ST_CLOSE;
					end else begin
						state_q <= ST_FLAG;
					end
				end
				ST_FLAG: begin
					if (!res_full) begin
						if (!mode || idx_q == IW'(RESERVED_BYTES - 1)) begin
							idx_q   <= '0;
							state_q <= ST_SLP;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_SLP: begin
					if (!res_full) begin
						idx_q   <= '0;
						state_q <= ST_SEG_RD;
					end
				end
				ST_SEG_RD: begin
					state_q <= ST_SEG_WR;
				end
				ST_SEG_WR: begin
					if (!res_full) begin
						if (idx_q == IW'(sfa_pkg::SEG_BYTES - 1)) begin
							state_q <= ST_CLOSE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_SEG_RD;
						end
					end
				end
				ST_CLOSE: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
